### rtl/crrm_pkg.sv
// ----------------------------------------------------------------------------
// crrm_pkg
// Shared types and constants for the connector relative rotation match block.
// ----------------------------------------------------------------------------
package crrm_pkg;

    localparam int unsigned ROM_FRAC = 30;
    localparam int unsigned ROM_LAST = 90;
    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam int unsigned TOL_W    = 20;
    localparam logic [TOL_W-1:0] TOL_RESET = 20'd105;

    // (2n)(2n+1) Taylor divisors, index 0 unused
    localparam logic [63:0] TAYLOR_DIV [0:19] = '{
        64'd1,    64'd6,    64'd20,   64'd42,   64'd72,
        64'd110,  64'd156,  64'd210,  64'd272,  64'd342,
        64'd420,  64'd506,  64'd600,  64'd702,  64'd812,
        64'd930,  64'd1056, 64'd1190, 64'd1332, 64'd1482
    };

    typedef struct packed {
        logic [1:0] connector;
        logic [8:0] local_roll;
        logic [8:0] local_pitch;
        logic [8:0] local_yaw;
        logic [8:0] remote_roll;
        logic [8:0] remote_pitch;
        logic [8:0] remote_yaw;
    } t_crrm_in;

    typedef struct packed {
        logic       match_found;
        logic [1:0] quarter_turns;
    } t_crrm_out;

    typedef struct packed {
        logic [6:0] idx;
        logic       neg;
    } t_rom_sel;

    // Q30 sine of k degrees by truncated Taylor series (elaboration only)
    function automatic logic [63:0] rom_q30(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic               done;
        begin
            x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
            x2   = (x * x) >> ROM_FRAC;
            term = x;
            sum  = $signed(x);
            done = 1'b0;
            for (int n = 1; n < 20; n++) begin
                if (!done && term != 64'd0) begin
                    term = (term * x2) >> ROM_FRAC;
                    term = term / TAYLOR_DIV[n];
                    if ((n % 2) == 1)
                        sum = sum - $signed(term);
                    else
                        sum = sum + $signed(term);
                end else begin
                    done = 1'b1;
                end
            end
            if (sum < 0)
                sum = 64'sd0;
            if (sum > $signed(64'd1 << ROM_FRAC))
                sum = $signed(64'd1 << ROM_FRAC);
            if (k == 0)
                sum = 64'sd0;
            if (k == ROM_LAST)
                sum = $signed(64'd1 << ROM_FRAC);
            return $unsigned(sum);
        end
    endfunction

endpackage

### rtl/connector_relative_rotation_match.sv
// ----------------------------------------------------------------------------
// connector_relative_rotation_match
// Finds the quarter turn that maps a remote module's Z axis onto the local one.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one query word:
//   connector and the local and remote Euler angles in degrees.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns one word
//   per query: match_found and quarter_turns, in query order.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the match
//   tolerance; always ready. Write it only with the pipe empty.
//   Six stages (table lookup, remote axis, three local rotations, compare)
//   lie between acceptance and o_out_valid. Throughput: one word per cycle
//   while the receiver is ready; stages two to five each hold a multiply-add pair.
//   Reset empties the pipe and sets the tolerance to 105.
//   When the receiver stalls, words pile up in free stages; o_in_ready drops
//   only once every stage is full. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module connector_relative_rotation_match import crrm_pkg::*; #(
    parameter int FRAC_BITS = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_crrm_in         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_crrm_out        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [TOL_W-1:0] i_cfg_data
);
    localparam int CW = FRAC_BITS + 2;
    localparam int VW = FRAC_BITS + 3;
    localparam int NST = 6;

    typedef logic signed [CW-1:0] t_coef;
    typedef logic signed [VW-1:0] t_vec;

    logic [NST:1] r_vld;
    logic [NST:1] en;
    logic [TOL_W-1:0] r_tol;

    // handshake chain
    always_comb begin
        en[NST] = !r_vld[NST] || i_out_ready;
        for (int k = NST - 1; k >= 1; k--)
            en[k] = !r_vld[k] || en[k+1];
    end

    assign o_in_ready  = en[1];
    assign o_out_valid = r_vld[NST];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_tol <= TOL_RESET;
        end else begin
            if (i_cfg_valid)
                r_tol <= i_cfg_data;
            if (en[1])
                r_vld[1] <= i_in_valid;
            for (int k = 2; k <= NST; k++)
                if (en[k])
                    r_vld[k] <= r_vld[k-1];
        end
    end

    // stage 1: trig lookup
    t_coef n_srp, n_crp, n_sry, n_cry, n_slr, n_clr, n_slp, n_clp, n_sly, n_cly;

    crrm_trig #(.FRAC_BITS(FRAC_BITS)) u_trig_rp (
        .i_angle(i_in_data.remote_pitch), .o_sin(n_srp), .o_cos(n_crp));
    crrm_trig #(.FRAC_BITS(FRAC_BITS)) u_trig_ry (
        .i_angle(i_in_data.remote_yaw), .o_sin(n_sry), .o_cos(n_cry));
    crrm_trig #(.FRAC_BITS(FRAC_BITS)) u_trig_lr (
        .i_angle(i_in_data.local_roll), .o_sin(n_slr), .o_cos(n_clr));
    crrm_trig #(.FRAC_BITS(FRAC_BITS)) u_trig_lp (
        .i_angle(i_in_data.local_pitch), .o_sin(n_slp), .o_cos(n_clp));
    crrm_trig #(.FRAC_BITS(FRAC_BITS)) u_trig_ly (
        .i_angle(i_in_data.local_yaw), .o_sin(n_sly), .o_cos(n_cly));

    logic [1:0] r_conn1, r_conn2, r_conn3, r_conn4, r_conn5;
    t_coef r1_srp, r1_crp, r1_sry, r1_cry, r1_slr, r1_clr, r1_slp, r1_clp, r1_sly, r1_cly;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_conn1 <= i_in_data.connector;
            r1_srp  <= n_srp;  r1_crp <= n_crp;
            r1_sry  <= n_sry;  r1_cry <= n_cry;
            r1_slr  <= n_slr;  r1_clr <= n_clr;
            r1_slp  <= n_slp;  r1_clp <= n_clp;
            r1_sly  <= n_sly;  r1_cly <= n_cly;
        end
    end

    // stage 2: remote axis in world frame, w = (sp, -sy*cp, cy*cp)
    t_vec n_w1, n_w2;
    crrm_rot #(.FRAC_BITS(FRAC_BITS)) u_rot_w (
        .i_c(r1_cry), .i_s(r1_sry), .i_a(VW'(r1_crp)), .i_b('0),
        .o_a(n_w2), .o_b(n_w1));

    t_vec  r2_w0, r2_w1, r2_w2;
    t_coef r2_slr, r2_clr, r2_slp, r2_clp, r2_sly, r2_cly;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_conn2 <= r_conn1;
            r2_w0   <= VW'(r1_srp);
            r2_w1   <= n_w1;
            r2_w2   <= n_w2;
            r2_slr  <= r1_slr; r2_clr <= r1_clr;
            r2_slp  <= r1_slp; r2_clp <= r1_clp;
            r2_sly  <= r1_sly; r2_cly <= r1_cly;
        end
    end

    // stage 3: undo local yaw
    t_vec n_u1, n_u2;
    crrm_rot #(.FRAC_BITS(FRAC_BITS)) u_rot_yaw (
        .i_c(r2_cly), .i_s(r2_sly), .i_a(r2_w1), .i_b(r2_w2),
        .o_a(n_u1), .o_b(n_u2));

    t_vec  r3_w0, r3_u1, r3_u2;
    t_coef r3_slr, r3_clr, r3_slp, r3_clp;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_conn3 <= r_conn2;
            r3_w0   <= r2_w0;
            r3_u1   <= n_u1;
            r3_u2   <= n_u2;
            r3_slr  <= r2_slr; r3_clr <= r2_clr;
            r3_slp  <= r2_slp; r3_clp <= r2_clp;
        end
    end

    // stage 4: undo local pitch
    t_vec n_t0, n_t2;
    crrm_rot #(.FRAC_BITS(FRAC_BITS)) u_rot_pitch (
        .i_c(r3_clp), .i_s(r3_slp), .i_a(r3_u2), .i_b(r3_w0),
        .o_a(n_t2), .o_b(n_t0));

    t_vec  r4_t0, r4_t1, r4_t2;
    t_coef r4_slr, r4_clr;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_conn4 <= r_conn3;
            r4_t0   <= n_t0;
            r4_t1   <= r3_u1;
            r4_t2   <= n_t2;
            r4_slr  <= r3_slr;
            r4_clr  <= r3_clr;
        end
    end

    // stage 5: undo local roll
    t_vec n_n0, n_n1;
    crrm_rot #(.FRAC_BITS(FRAC_BITS)) u_rot_roll (
        .i_c(r4_clr), .i_s(r4_slr), .i_a(r4_t0), .i_b(r4_t1),
        .o_a(n_n0), .o_b(n_n1));

    t_vec r5_n0, r5_n1, r5_n2;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_conn5 <= r_conn4;
            r5_n0   <= n_n0;
            r5_n1   <= n_n1;
            r5_n2   <= r4_t2;
        end
    end

    // stage 6: target compare, output register
    t_crrm_out n_result;
    t_crrm_out r_result;

    crrm_match #(.FRAC_BITS(FRAC_BITS)) u_match (
        .i_n0(r5_n0), .i_n1(r5_n1), .i_n2(r5_n2),
        .i_connector(r_conn5), .i_tol(r_tol), .o_result(n_result));

    always_ff @(posedge i_clk) begin
        if (en[6])
            r_result <= n_result;
    end

    assign o_out_data = r_result;

    // checks
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("pipe not empty after reset");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == {NST{1'b1}} && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while pipe full and stalled");

    a_tol_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> r_tol == $past(i_cfg_data))
        else $error("tolerance write lost");

    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.match_found) |-> o_out_data.quarter_turns == 2'd0)
        else $error("quarter_turns set without a match");

endmodule

### rtl/crrm_trig.sv
// ----------------------------------------------------------------------------
// crrm_trig
// Sine and cosine of an integer-degree angle from a quarter-wave table.
// ----------------------------------------------------------------------------
module crrm_trig import crrm_pkg::*; #(
    parameter int FRAC_BITS = 20
) (
    input  logic [8:0]                   i_angle,
    output logic signed [FRAC_BITS+1:0]  o_sin,
    output logic signed [FRAC_BITS+1:0]  o_cos
);
    localparam int CW = FRAC_BITS + 2;
    localparam int SH = ROM_FRAC - FRAC_BITS;
    localparam logic [63:0] HALF = (SH == 0) ? 64'd0 : (64'd1 << (SH - 1));

    logic [FRAC_BITS:0] rom [0:ROM_LAST];

    for (genvar k = 0; k <= ROM_LAST; k++) begin : g_rom
        localparam logic [63:0] V = rom_q30(k);
        localparam logic [63:0] R = (V + HALF) >> SH;
        assign rom[k] = R[FRAC_BITS:0];
    end

    function automatic t_rom_sel map_deg(input logic [9:0] d);
        logic [9:0] e;
        t_rom_sel   s;
        begin
            e = (d >= 10'd360) ? d - 10'd360 : d;
            if (e <= 10'd90) begin
                s.idx = e[6:0];
                s.neg = 1'b0;
            end else if (e <= 10'd180) begin
                s.idx = 7'(10'd180 - e);
                s.neg = 1'b0;
            end else if (e <= 10'd270) begin
                s.idx = 7'(e - 10'd180);
                s.neg = 1'b1;
            end else begin
                s.idx = 7'(10'd360 - e);
                s.neg = 1'b1;
            end
            return s;
        end
    endfunction

    logic [9:0]          deg;
    t_rom_sel            sel_s;
    t_rom_sel            sel_c;
    logic signed [CW-1:0] mag_s;
    logic signed [CW-1:0] mag_c;

    always_comb begin
        deg = {1'b0, i_angle};
        if (deg >= 10'd360)
            deg = deg - 10'd360;
    end

    assign sel_s = map_deg(deg);
    assign sel_c = map_deg(deg + 10'd90);
    assign mag_s = $signed({1'b0, rom[sel_s.idx]});
    assign mag_c = $signed({1'b0, rom[sel_c.idx]});
    assign o_sin = sel_s.neg ? -mag_s : mag_s;
    assign o_cos = sel_c.neg ? -mag_c : mag_c;

endmodule

### rtl/crrm_rot.sv
// ----------------------------------------------------------------------------
// crrm_rot
// Plane rotation: a' = c*a + s*b, b' = c*b - s*a, each rounded to nearest.
// ----------------------------------------------------------------------------
module crrm_rot import crrm_pkg::*; #(
    parameter int FRAC_BITS = 20
) (
    input  logic signed [FRAC_BITS+1:0] i_c,
    input  logic signed [FRAC_BITS+1:0] i_s,
    input  logic signed [FRAC_BITS+2:0] i_a,
    input  logic signed [FRAC_BITS+2:0] i_b,
    output logic signed [FRAC_BITS+2:0] o_a,
    output logic signed [FRAC_BITS+2:0] o_b
);
    localparam int VW = FRAC_BITS + 3;
    localparam int PW = 2 * FRAC_BITS + 5;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

    logic signed [PW-1:0] p_ca, p_sb, p_cb, p_sa;
    logic signed [SW-1:0] sum_a, sum_b, rnd_a, rnd_b;

    assign p_ca = PW'(i_c) * PW'(i_a);
    assign p_sb = PW'(i_s) * PW'(i_b);
    assign p_cb = PW'(i_c) * PW'(i_b);
    assign p_sa = PW'(i_s) * PW'(i_a);

    assign sum_a = SW'(p_ca) + SW'(p_sb) + HALF;
    assign sum_b = SW'(p_cb) - SW'(p_sa) + HALF;
    assign rnd_a = sum_a >>> FRAC_BITS;
    assign rnd_b = sum_b >>> FRAC_BITS;
    assign o_a   = rnd_a[VW-1:0];
    assign o_b   = rnd_b[VW-1:0];

endmodule

### rtl/crrm_match.sv
// ----------------------------------------------------------------------------
// crrm_match
// Compares the turned axis with the four quarter-turn targets.
// ----------------------------------------------------------------------------
module crrm_match import crrm_pkg::*; #(
    parameter int FRAC_BITS = 20
) (
    input  logic signed [FRAC_BITS+2:0] i_n0,
    input  logic signed [FRAC_BITS+2:0] i_n1,
    input  logic signed [FRAC_BITS+2:0] i_n2,
    input  logic [1:0]                  i_connector,
    input  logic [TOL_W-1:0]            i_tol,
    output t_crrm_out                   o_result
);
    localparam int DW = FRAC_BITS + 5;
    localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;
    localparam logic signed [DW-1:0] ZERO = '0;

    logic signed [DW-1:0] n_ext [3];
    logic signed [DW-1:0] tgt [4][3];
    logic [3:0]           ok;
    logic [DW-1:0]        tol_ext;

    function automatic logic close(input logic signed [DW-1:0] t,
                                   input logic signed [DW-1:0] v,
                                   input logic [DW-1:0]        tol);
        logic signed [DW-1:0] d;
        logic [DW-1:0]        m;
        begin
            d = t - v;
            m = (d < 0) ? $unsigned(-d) : $unsigned(d);
            return (m <= tol);
        end
    endfunction

    assign tol_ext  = DW'(i_tol);
    assign n_ext[0] = DW'(i_n0);
    assign n_ext[1] = DW'(i_n1);
    assign n_ext[2] = DW'(i_n2);

    always_comb begin
        tgt[0] = '{ZERO, ZERO, ONE};
        tgt[2] = '{ZERO, ZERO, -ONE};
        if (!i_connector[0]) begin
            tgt[1] = '{ONE, ZERO, ZERO};
            tgt[3] = '{-ONE, ZERO, ZERO};
        end else begin
            tgt[1] = '{ZERO, -ONE, ZERO};
            tgt[3] = '{ZERO, ONE, ZERO};
        end
        for (int i = 0; i < 4; i++)
            ok[i] = close(tgt[i][0], n_ext[0], tol_ext) &&
                    close(tgt[i][1], n_ext[1], tol_ext) &&
                    close(tgt[i][2], n_ext[2], tol_ext);
    end

    always_comb begin
        o_result = '0;
        if (ok[0]) begin
            o_result = '{match_found: 1'b1, quarter_turns: 2'd0};
        end else if (ok[1]) begin
            o_result = '{match_found: 1'b1, quarter_turns: 2'd1};
        end else if (ok[2]) begin
            o_result = '{match_found: 1'b1, quarter_turns: 2'd2};
        end else if (ok[3]) begin
            o_result = '{match_found: 1'b1, quarter_turns: 2'd3};
        end
    end

endmodule
